>>> rtl/core/lde_pkg.sv
package lde_pkg;

  localparam int DATA_W        = 32;
  localparam int ACTION_W      = 2;
  localparam int SCALE_W       = 31;
  localparam int CFG_IDX_W     = 1;
  localparam int FRAC_BITS_DEF = 16;

  // Action codes carried by the input item.
  localparam logic [ACTION_W-1:0] ACT_PDF = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CDF = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QNT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MU    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd1;

  // Fixed-point constants: log2(e) in Q.32, ln(2) in Q.32 and Q.28.
  localparam logic [32:0] LOG2E_Q32 = 33'h1_7154_7653;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
  localparam logic [27:0] LN2_Q28   = 28'hB17_217F;

endpackage

>>> rtl/core/lde_in_if.sv
interface lde_in_if;
  logic                                valid;
  logic                                ready;
  logic [lde_pkg::ACTION_W-1:0]        action;
  logic signed [lde_pkg::DATA_W-1:0]   argument;

  modport source (output valid, output action, output argument, input ready);
  modport sink   (input valid, input action, input argument, output ready);
endinterface

>>> rtl/core/lde_out_if.sv
interface lde_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lde_pkg::DATA_W-1:0]   value_out;
  logic                                domain_error;
  logic                                saturated;

  modport source (output valid, output value_out, output domain_error, output saturated,
                  input ready);
  modport sink   (input valid, input value_out, input domain_error, input saturated,
                  output ready);
endinterface

>>> rtl/core/lde_cfg_if.sv
interface lde_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lde_pkg::CFG_IDX_W-1:0]       index;
  logic [lde_pkg::DATA_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/logistic_distribution_eval.sv
// Channel   Modport  Payload                                   Transfer when
// in_ch     sink     action, argument                          valid & ready
// out_ch    source   value_out, domain_error, saturated        valid & ready
// cfg_ch    sink     index, data (register write)              valid & ready
//
// One item enters per cycle while the output is not stalled; the pipeline depth is
// set by the three restoring dividers (one quotient bit per stage) and the
// twenty-four-stage exponential series (two stages per Horner step), and the
// quantile lane runs beside them.
// Reset is synchronous and active low; it clears the valid bits and sets the
// location to 0.0 and the scale to 1.0.
// A stall at the output freezes the whole pipeline, so nothing is lost or
// repeated; the last stage is the output register.
module logistic_distribution_eval #(
  parameter int FRAC_BITS = lde_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lde_in_if.sink      in_ch,
  lde_out_if.source   out_ch,
  lde_cfg_if.sink     cfg_ch
);

  // Density divisor is scale shifted left by SH; its width follows FRAC_BITS.
  localparam int SH  = 62 - 2 * FRAC_BITS;
  localparam int SDW = 31 + SH;
  localparam int CSH = 31 - FRAC_BITS;

  // Stage map.
  localparam int ST_D1A = 2;
  localparam int ST_D1B = 31;
  localparam int ST_XU  = 32;
  localparam int ST_XY  = 33;
  localparam int ST_HA  = 34;
  localparam int ST_HB  = 57;
  localparam int ST_E   = 58;
  localparam int ST_D2A = 59;
  localparam int ST_D2B = 90;
  localparam int ST_LO  = 91;
  localparam int ST_P   = 92;
  localparam int ST_D3I = 93;
  localparam int ST_D3A = 94;
  localparam int ST_D3B = 124;
  localparam int NST    = 125;

  localparam logic signed [31:0] ONE_F = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic [1:0]      action;
    logic            dneg;
    logic            clamp;
    logic            qdom;
    logic [31:0]     rem1;
    logic [29:0]     nlo;
    logic [29:0]     tq;
    logic [30:0]     u;
    logic [6:0]      n;
    logic [31:0]     y;
    logic [32:0]     acc;
    logic [31:0]     hsh;
    logic [33:0]     dd;
    logic [33:0]     rem2;
    logic [31:0]     hq;
    logic [30:0]     lo;
    logic [31:0]     cres;
    logic [61:0]     prod;
    logic            dsat;
    logic [SDW-1:0]  rem3;
    logic [30:0]     plow;
    logic [30:0]     dq;
    logic [30:0]     m1;
    logic [30:0]     m2;
    logic [29:0]     fr1;
    logic [29:0]     fr2;
    logic [4:0]      msb1;
    logic [4:0]      msb2;
    logic            qneg;
    logic [34:0]     mag;
    logic [34:0]     lnm;
    logic [50:0]     sa;
    logic [45:0]     sb;
    logic [31:0]     qval;
    logic            qsat;
    logic [31:0]     value;
    logic            derr;
    logic            sat;
  } item_t;

  logic signed [31:0] mu_r;
  logic [30:0]        s_r;
  logic [30:0]        s_eff;
  logic [SDW-1:0]     sd;
  logic               en;
  item_t              entry_item;
  item_t              pipe_r [1:NST];
  logic               vld_r  [1:NST];

  // A scale of zero behaves as the smallest scale.
  assign s_eff = (s_r == '0) ? 31'd1 : s_r;
  assign sd    = {s_eff, {SH{1'b0}}};

  // The pipeline moves whenever the output register is empty or being drained.
  assign en           = !vld_r[NST] || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= '0;
      s_r  <= 31'(32'd1 << FRAC_BITS);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lde_pkg::REG_MU:    mu_r <= cfg_ch.data;
        lde_pkg::REG_SCALE: s_r  <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  function automatic logic [4:0] msb_of(logic [FRAC_BITS-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  // Entry: distance from the location, clamp test, divider setup, and the
  // normalized mantissas of p and 1-p for the quantile lane.
  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        ad;
    logic [31:0]        pc;
    logic [FRAC_BITS-1:0] v1;
    logic [FRAC_BITS-1:0] v2;
    logic [4:0]         b1;
    logic [4:0]         b2;
    d  = {in_ch.argument[31], in_ch.argument} - {mu_r[31], mu_r};
    ad = d[32] ? 33'(-d) : 33'(d);
    pc = 32'(ONE_F - in_ch.argument);
    v1 = in_ch.argument[FRAC_BITS-1:0];
    v2 = pc[FRAC_BITS-1:0];
    b1 = msb_of(v1);
    b2 = msb_of(v2);
    entry_item        = '0;
    entry_item.action = in_ch.action;
    entry_item.dneg   = d[32];
    entry_item.clamp  = {4'b0, ad} >= {s_eff, 6'b0};
    entry_item.rem1   = {5'b0, ad[32:6]};
    entry_item.nlo    = {ad[5:0], 24'b0};
    entry_item.qdom   = in_ch.argument[31] || (in_ch.argument == '0) ||
                        (in_ch.argument >= ONE_F);
    entry_item.m1     = 31'({{(31-FRAC_BITS){1'b0}}, v1}) << (5'd30 - b1);
    entry_item.m2     = 31'({{(31-FRAC_BITS){1'b0}}, v2}) << (5'd30 - b2);
    entry_item.msb1   = b1;
    entry_item.msb2   = b2;
  end

  // One quotient bit of |t| = |x-mu| * 2^24 / s.
  function automatic item_t f_div1(item_t i, logic [30:0] s);
    item_t      o;
    logic [32:0] r;
    logic        qb;
    o  = i;
    r  = {i.rem1, i.nlo[29]};
    qb = r >= {2'b0, s};
    if (qb) begin
      r = r - {2'b0, s};
    end
    o.rem1 = r[31:0];
    o.nlo  = {i.nlo[28:0], 1'b0};
    o.tq   = {i.tq[28:0], qb};
    return o;
  endfunction

  // One squaring step of the log2 fraction for both p and 1-p.
  function automatic item_t f_sqr(item_t i);
    item_t       o;
    logic [61:0] p1;
    logic [61:0] p2;
    o  = i;
    p1 = 62'(i.m1) * 62'(i.m1);
    p2 = 62'(i.m2) * 62'(i.m2);
    o.m1  = p1[61] ? p1[61:31] : p1[60:30];
    o.fr1 = {i.fr1[28:0], p1[61]};
    o.m2  = p2[61] ? p2[61:31] : p2[60:30];
    o.fr2 = {i.fr2[28:0], p2[61]};
    return o;
  endfunction

  // One quotient bit of hi = 2^63 / (2^32 + E).
  function automatic item_t f_div2(item_t i);
    item_t       o;
    logic [34:0] r;
    logic        qb;
    o  = i;
    r  = {i.rem2, 1'b0};
    qb = r >= {1'b0, i.dd};
    if (qb) begin
      r = r - {1'b0, i.dd};
    end
    o.rem2 = r[33:0];
    o.hq   = {i.hq[30:0], qb};
    return o;
  endfunction

  // One quotient bit of the density divide.
  function automatic item_t f_div3(item_t i, logic [SDW-1:0] dv);
    item_t        o;
    logic [SDW:0] r;
    logic         qb;
    o  = i;
    r  = {i.rem3, i.plow[30]};
    qb = r >= {1'b0, dv};
    if (qb) begin
      r = r - {1'b0, dv};
    end
    o.rem3 = r[SDW-1:0];
    o.plow = {i.plow[29:0], 1'b0};
    o.dq   = {i.dq[29:0], qb};
    return o;
  endfunction

  genvar g;
  generate
    for (g = 1; g <= NST; g++) begin : g_st
      item_t prv;
      item_t nxt;

      if (g == 1) begin : g_src
        assign prv = entry_item;
      end else begin : g_prv
        assign prv = pipe_r[g-1];
      end

      if (g == 1) begin : g_in
        assign nxt = prv;
      end else if (g >= ST_D1A && g <= ST_D1B) begin : g_d1
        assign nxt = f_sqr(f_div1(prv, s_eff));
      end else if (g == ST_XU) begin : g_xu
        // Split exp(-t) into 2^-n * exp(-y); also form the log2 difference.
        always_comb begin
          logic [30:0]        t;
          logic [63:0]        pu;
          logic signed [35:0] diff;
          t    = prv.clamp ? 31'(32'd64 << 24) : {1'b0, prv.tq};
          pu   = 64'(t) * 64'(lde_pkg::LOG2E_Q32);
          diff = $signed({1'b0, prv.msb1, prv.fr1}) - $signed({1'b0, prv.msb2, prv.fr2});
          nxt      = prv;
          nxt.u    = pu[62:32];
          nxt.qneg = diff[35];
          nxt.mag  = diff[35] ? 35'(-diff) : diff[34:0];
        end
      end else if (g == ST_XY) begin : g_xy
        always_comb begin
          logic [55:0] py;
          logic [62:0] pl;
          py = 56'(prv.u[23:0]) * 56'(lde_pkg::LN2_Q32);
          pl = 63'(prv.mag) * 63'(lde_pkg::LN2_Q28);
          nxt     = prv;
          nxt.n   = prv.u[30:24];
          nxt.y   = py[55:24];
          nxt.acc = 33'h1_0000_0000;
          nxt.lnm = pl[62:28];
        end
      end else if (g >= ST_HA && g <= ST_HB) begin : g_h
        // Horner step of the series for exp(-y), divisor counting down from 12.
        // Each step takes two stages: the product with y, then the divide by k as a
        // multiply by ceil(2^(32+l)/k), which is exact for any dividend below 2^32.
        localparam int          HJ   = g - ST_HA;
        localparam int unsigned Kdiv = 12 - HJ / 2;
        localparam int          KL   = $clog2(Kdiv);
        localparam logic [32:0] KREC =
          33'(((64'd1 << (32 + KL)) + 64'(Kdiv) - 64'd1) / 64'(Kdiv));
        always_comb begin
          logic [63:0]        pa;
          logic [64:0]        pq;
          logic [51:0]        sum;
          logic [36:0]        term;
          logic signed [38:0] res;
          pa   = '0;
          pq   = '0;
          nxt  = prv;
          if ((HJ % 2) == 0) begin
            pa      = 64'(prv.y) * 64'(prv.acc);
            nxt.hsh = pa[63:32];
          end else begin
            pq      = 65'(prv.hsh) * 65'(KREC);
            nxt.acc = 33'h1_0000_0000 - 33'(pq >> (32 + KL));
          end
          sum  = '0;
          term = '0;
          res  = '0;
          if (g == ST_HA) begin
            nxt.sa = 51'(s_eff) * 51'(prv.lnm[34:15]);
            nxt.sb = 46'(s_eff) * 46'(prv.lnm[14:0]);
          end else if (g == ST_HA + 1) begin
            sum  = {1'b0, prv.sa} + 52'(prv.sb[45:15]);
            term = sum[51:15];
            res  = prv.qneg ? ($signed({{7{mu_r[31]}}, mu_r}) - $signed({2'b0, term}))
                            : ($signed({{7{mu_r[31]}}, mu_r}) + $signed({2'b0, term}));
            if (res > 39'sd2147483647) begin
              nxt.qval = 32'h7FFF_FFFF;
              nxt.qsat = 1'b1;
            end else if (res < -39'sd2147483648) begin
              nxt.qval = 32'h8000_0000;
              nxt.qsat = 1'b1;
            end else begin
              nxt.qval = res[31:0];
              nxt.qsat = 1'b0;
            end
          end
        end
      end else if (g == ST_E) begin : g_e
        always_comb begin
          logic [32:0] e;
          e = (prv.n >= 7'd63) ? 33'd0 : (prv.acc >> prv.n);
          nxt      = prv;
          nxt.dd   = 34'h1_0000_0000 + 34'(e);
          nxt.rem2 = 34'h0_8000_0000;
          nxt.hq   = '0;
        end
      end else if (g >= ST_D2A && g <= ST_D2B) begin : g_d2
        assign nxt = f_div2(prv);
      end else if (g == ST_LO) begin : g_lo
        // lo = 2^31 - ceil(2^63 / D), from the same quotient and remainder.
        always_comb begin
          logic [31:0] lo;
          logic [31:0] c;
          lo = 32'h8000_0000 - prv.hq - 32'(|prv.rem2);
          c  = prv.dneg ? lo : prv.hq;
          nxt      = prv;
          nxt.lo   = lo[30:0];
          nxt.cres = c >> CSH;
        end
      end else if (g == ST_P) begin : g_p
        always_comb begin
          logic [62:0] pp;
          pp = 63'(prv.hq) * 63'(prv.lo);
          nxt      = prv;
          nxt.prod = pp[61:0];
        end
      end else if (g == ST_D3I) begin : g_d3i
        always_comb begin
          nxt      = prv;
          nxt.dsat = SDW'(prv.prod[61:31]) >= sd;
          nxt.rem3 = SDW'(prv.prod[61:31]);
          nxt.plow = prv.prod[30:0];
          nxt.dq   = '0;
        end
      end else if (g >= ST_D3A && g <= ST_D3B) begin : g_d3
        assign nxt = f_div3(prv, sd);
      end else begin : g_out
        always_comb begin
          nxt = prv;
          case (prv.action)
            lde_pkg::ACT_PDF: begin
              nxt.value = prv.dsat ? 32'h7FFF_FFFF : {1'b0, prv.dq};
              nxt.derr  = 1'b0;
              nxt.sat   = prv.dsat;
            end
            lde_pkg::ACT_CDF: begin
              nxt.value = prv.cres;
              nxt.derr  = 1'b0;
              nxt.sat   = 1'b0;
            end
            lde_pkg::ACT_QNT: begin
              nxt.value = prv.qdom ? 32'd0 : prv.qval;
              nxt.derr  = prv.qdom;
              nxt.sat   = prv.qdom ? 1'b0 : prv.qsat;
            end
            default: begin
              nxt.value = '0;
              nxt.derr  = 1'b1;
              nxt.sat   = 1'b0;
            end
          endcase
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (en) begin
          vld_r[g] <= (g == 1) ? in_ch.valid : vld_r[(g == 1) ? 1 : g - 1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[g] <= nxt;
        end
      end
    end
  endgenerate

  assign out_ch.valid        = vld_r[NST];
  assign out_ch.value_out    = pipe_r[NST].value;
  assign out_ch.domain_error = pipe_r[NST].derr;
  assign out_ch.saturated    = pipe_r[NST].sat;

`ifndef ASSERT_OFF
  a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.domain_error |-> out_ch.value_out == '0 && !out_ch.saturated)
    else $error("domain error with nonzero result");

  a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && pipe_r[NST].action == lde_pkg::ACT_CDF |->
      !out_ch.saturated && !out_ch.value_out[31])
    else $error("cumulative result out of range");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(en) |-> vld_r[1] == $past(in_ch.valid))
    else $error("accepted item not captured");

  a_div2_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_D2B] |-> pipe_r[ST_D2B].rem2 < pipe_r[ST_D2B].dd)
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> test/logistic_distribution_eval_test.sv
`timescale 1ns / 100ps

module logistic_distribution_eval_test;

  localparam int ACTION_W  = lde_pkg::ACTION_W;
  localparam int DATA_W    = lde_pkg::DATA_W;
  localparam int SCALE_W   = lde_pkg::SCALE_W;
  localparam int CFG_IDX_W = lde_pkg::CFG_IDX_W;

  // The action code that the block does not define.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // One request as the sender presents it.
  typedef struct {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] argument;
  } request_t;

  // One result as the block returns it.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     derr;
    logic                     sat;
  } outcome_t;

  localparam longint unsigned ONE_Q32   = 64'd1 << 32;
  localparam longint          SAT_HI    = 64'sd2147483647;
  localparam longint          SAT_LO    = -64'sd2147483648;
  localparam int              CYCLE_CAP = 400000;
  localparam int              DRAIN     = 150;

  logic clk;
  logic rst_n;

  lde_in_if  in_ch();
  lde_out_if out_ch();
  lde_cfg_if cfg_ch();

  logistic_distribution_eval uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Our own copy of the two configuration registers, updated on each config transfer.
  logic signed [DATA_W-1:0]  location_q;
  logic [SCALE_W-1:0]        scale_q;

  request_t pending_requests[$];
  outcome_t expected_results[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  error_count;
  int  cycle_count;
  bit  in_taken;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Base-2 logarithm of an integer in [1, 2^31) as Q.30, by normalization followed
  // by repeated squaring of the mantissa, one fraction bit per squaring.
  function automatic longint unsigned log2_fixed(longint unsigned v);
    longint unsigned msb;
    longint unsigned m;
    longint unsigned frac;
    msb  = 0;
    frac = 0;
    while (msb < 30 && (v >> (msb + 1)) != 0) msb++;
    m = v << (30 - msb);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (msb << 30) + frac;
  endfunction

  // Predicts the result of one request under the current location and scale.
  function automatic outcome_t logistic_eval(request_t req);
    outcome_t        o;
    longint unsigned s, ad, t, u, n, y, acc, e, hi, lo, c, r, mag, lnm, a, b;
    longint          mu, d, diff, term, res, one;
    o.value = '0;
    o.derr  = 1'b0;
    o.sat   = 1'b0;
    s   = (scale_q == 0) ? 64'd1 : longint'(scale_q);
    mu  = longint'(location_q);
    one = 64'sd1 << 16;
    if (req.action == lde_pkg::ACT_PDF || req.action == lde_pkg::ACT_CDF) begin
      d  = longint'(req.argument) - mu;
      ad = (d < 0) ? -d : d;
      // The normalized distance saturates at 64.0 in Q.24.
      if (ad >= (s << 6)) t = 64'd64 << 24;
      else t = (ad << 24) / s;
      // exp(-t) = 2^-n * exp(-y), with exp(-y) from a twelve-term Horner series.
      u   = (t * 64'h1_7154_7653) >> 32;
      n   = u >> 24;
      y   = ((u & 64'hFF_FFFF) * 64'hB172_17F8) >> 24;
      acc = ONE_Q32;
      for (int k = 12; k >= 1; k--) acc = ONE_Q32 - ((y * acc) >> 32) / k;
      e  = (n >= 63) ? 64'd0 : (acc >> n);
      hi = (64'd1 << 63) / (ONE_Q32 + e);
      lo = (e << 31) / (ONE_Q32 + e);
      if (req.action == lde_pkg::ACT_CDF) begin
        c = (d >= 0) ? hi : lo;
        o.value = DATA_W'(c >> 15);
      end else begin
        r = ((hi * lo) / s) >> 30;
        if (r > 64'd2147483647) begin
          o.value = DATA_W'(SAT_HI);
          o.sat   = 1'b1;
        end else begin
          o.value = DATA_W'(r);
        end
      end
    end else if (req.action == lde_pkg::ACT_QNT) begin
      if (longint'(req.argument) <= 0 || longint'(req.argument) >= one) begin
        o.derr = 1'b1;
      end else begin
        diff = longint'(log2_fixed(longint'(req.argument)))
             - longint'(log2_fixed(one - longint'(req.argument)));
        mag  = (diff < 0) ? -diff : diff;
        lnm  = (mag * 64'h0B17_217F) >> 28;
        a    = lnm >> 15;
        b    = lnm & 64'h7FFF;
        term = longint'((s * a + ((s * b) >> 15)) >> 15);
        res  = (diff < 0) ? mu - term : mu + term;
        if (res > SAT_HI) begin
          o.value = DATA_W'(SAT_HI);
          o.sat   = 1'b1;
        end else if (res < SAT_LO) begin
          o.value = DATA_W'(SAT_LO);
          o.sat   = 1'b1;
        end else begin
          o.value = DATA_W'(res);
        end
      end
    end else begin
      // The unused action code is reported as a domain error.
      o.derr = 1'b1;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    error_count++;
    $display("mismatch in %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("logistic_distribution_eval_test failed");
      $finish;
    end
  end

  // Input side, rising edge: a transfer here means the block took the request, so
  // the expected result is computed now, with the registers in force at this edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      request_t req;
      req.action   = in_ch.action;
      req.argument = in_ch.argument;
      expected_results.push_back(logistic_eval(req));
      in_taken = 1'b1;
    end else begin
      in_taken = 1'b0;
    end
  end

  // Driver, falling edge: once the current request has been transferred (or none is
  // shown), present the next one unless the sender idles this cycle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.action   <= lde_pkg::ACT_PDF;
      in_ch.argument <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t req;
        req = pending_requests.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.action   <= req.action;
        in_ch.argument <= req.argument;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random; a stall freezes the whole pipeline inside.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.value_out, '0);
      end else begin
        outcome_t want;
        want = expected_results.pop_front();
        if (out_ch.value_out !== want.value)
          report_mismatch("value_out", out_ch.value_out, want.value);
        if (out_ch.domain_error !== want.derr)
          report_mismatch("domain_error", DATA_W'(out_ch.domain_error), DATA_W'(want.derr));
        if (out_ch.saturated !== want.sat)
          report_mismatch("saturated", DATA_W'(out_ch.saturated), DATA_W'(want.sat));
      end
    end
  end

  // Register write over the configuration channel; the local copy follows at the
  // edge where the transfer happens.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == lde_pkg::REG_MU) location_q = data;
    else scale_q = data[SCALE_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Blocks until the pipeline has nothing in flight.
  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic request_t make_request(logic [ACTION_W-1:0] act, longint arg);
    request_t r;
    r.action   = act;
    r.argument = DATA_W'(arg);
    return r;
  endfunction

  // Random request. Most arguments land where the curves actually change: within a
  // few scales of the location for density and cumulative, inside (0,1) or near its
  // edges for the quantile. The rest is raw noise over the field, bad action included.
  function automatic request_t random_request();
    int     pick;
    longint s;
    longint off;
    pick = $urandom_range(99);
    s    = (scale_q == 0) ? 1 : longint'(scale_q);
    if (pick < 60) begin
      off = (s * longint'($urandom_range(4095))) / 256 - 8 * s;
      return make_request(pick < 30 ? lde_pkg::ACT_PDF : lde_pkg::ACT_CDF,
                          longint'(location_q) + off);
    end else if (pick < 85) begin
      return make_request(lde_pkg::ACT_QNT, longint'($urandom_range(65535, 1)));
    end else if (pick < 90) begin
      return make_request(lde_pkg::ACT_QNT,
                          $urandom_range(1) ? 65536 : -longint'($urandom_range(9)));
    end else begin
      return make_request(ACTION_W'($urandom_range(3)), longint'($urandom()));
    end
  endfunction

  initial begin
    // Register settings per phase: location, raw 32-bit scale write.
    logic [DATA_W-1:0] mu_set[6];
    logic [DATA_W-1:0] sc_set[6];
    int                n_random;

    rst_n         = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = lde_pkg::REG_MU;
    cfg_ch.data   = '0;
    location_q    = '0;
    scale_q       = SCALE_W'(1 << 16);
    send_idle_pct = 17;
    recv_idle_pct = 52;

    // Phase 0 runs at the reset values; the others cover the register extremes,
    // including a zero scale (written with the unused top bit set) and a very small one.
    mu_set[1] = 32'h8000_0000;  sc_set[1] = 32'h7FFF_FFFF;
    mu_set[2] = 32'h7FFF_FFFF;  sc_set[2] = 32'h0000_0001;
    mu_set[3] = $urandom();     sc_set[3] = 32'h8000_0000;
    mu_set[4] = 32'h0003_8000;  sc_set[4] = 32'h0000_4000;
    mu_set[5] = $urandom();     sc_set[5] = $urandom();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at the reset setting: field extremes, each action, quantile
    // domain edges, and the unused action code.
    pending_requests.push_back(make_request(lde_pkg::ACT_PDF, 0));
    pending_requests.push_back(make_request(lde_pkg::ACT_CDF, 0));
    pending_requests.push_back(make_request(lde_pkg::ACT_PDF, 65536));
    pending_requests.push_back(make_request(lde_pkg::ACT_CDF, -65536));
    pending_requests.push_back(make_request(lde_pkg::ACT_CDF, 65536));
    pending_requests.push_back(make_request(lde_pkg::ACT_PDF, 2147483647));
    pending_requests.push_back(make_request(lde_pkg::ACT_PDF, -2147483648));
    pending_requests.push_back(make_request(lde_pkg::ACT_CDF, 2147483647));
    pending_requests.push_back(make_request(lde_pkg::ACT_CDF, -2147483648));
    pending_requests.push_back(make_request(lde_pkg::ACT_CDF, 64 * 65536 - 1));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, 32768));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, 1));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, 65535));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, 0));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, 65536));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, -1));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, 2147483647));
    pending_requests.push_back(make_request(lde_pkg::ACT_QNT, -2147483648));
    pending_requests.push_back(make_request(ACT_UNUSED, 12345));
    pending_requests.push_back(make_request(ACT_UNUSED, -1));

    for (int ph = 0; ph < 6; ph++) begin
      // Sender idles lightly first, then the receiver, then neither.
      if (ph < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 52;
      end else if (ph < 4) begin
        send_idle_pct = 52;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph > 0) begin
        wait_drained();
        write_register(lde_pkg::REG_MU, mu_set[ph]);
        write_register(lde_pkg::REG_SCALE, sc_set[ph]);
      end
      n_random = 108;
      for (int i = 0; i < n_random; i++) pending_requests.push_back(random_request());
    end

    wait_drained();
    if (error_count == 0) begin
      $display("logistic_distribution_eval_test passed");
    end else begin
      $display("logistic_distribution_eval_test failed");
    end
    $finish;
  end

endmodule
